// ----- sv/pfss_pkg.sv -----
// shared types, constants and control program of the roll steering controller
`default_nettype none
package pfss_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 12;

	localparam int  DATA_W   = 16;
	localparam int  OUT_W    = 13;
	localparam int  IDX_W    = 3;
	localparam int  STEP_W   = 4;
	localparam int  PROD_W   = 50;
	localparam int  SUM_W    = 40;
	localparam int  INTEG_W  = 32;
	localparam int  SLEW_W   = 18;
	localparam longint PI_Q28 = 64'd843314857;

	localparam logic [IDX_W-1:0] REG_GAIN_PROP    = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_INTEG   = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_DERIV   = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_FEEDFWD = 3'd3;
	localparam logic [IDX_W-1:0] REG_TIME_STEP    = 3'd4;

	localparam logic [DATA_W-1:0] RST_GAIN_PROP    = 16'd256;
	localparam logic [DATA_W-1:0] RST_GAIN_INTEG   = 16'd0;
	localparam logic [DATA_W-1:0] RST_GAIN_DERIV   = 16'd0;
	localparam logic [DATA_W-1:0] RST_GAIN_FEEDFWD = 16'd2176;
	localparam logic [DATA_W-1:0] RST_TIME_STEP    = 16'd328;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_ERR_DT,
		MUL_KP_ERR,
		MUL_KI_INT,
		MUL_KD_RATE,
		MUL_KF_DES,
		MUL_PI_DT
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_NOP,
		ACC_INTEG,
		ACC_LOAD,
		ACC_ADD_SHR,
		ACC_SUB,
		ACC_ADD,
		ACC_RAW,
		ACC_SLEW
	} acc_op_t;

	typedef enum logic [1:0] {
		COND_NEXT,
		COND_IN,
		COND_OUT
	} cond_t;

	typedef struct packed {
		mul_sel_t mul;
		acc_op_t  acc;
		cond_t    cond;
		logic     last;
	} ctrl_t;

	function automatic ctrl_t ucode(input logic [STEP_W-1:0] addr);
		ctrl_t c;
		c = '{mul: MUL_NONE, acc: ACC_NOP, cond: COND_NEXT, last: 1'b0};
		case (addr)
			4'd0: c.cond = COND_IN;
			4'd1: c.mul = MUL_ERR_DT;
			4'd2: begin
				c.mul = MUL_KP_ERR;
				c.acc = ACC_INTEG;
			end
			4'd3: begin
				c.mul = MUL_KI_INT;
				c.acc = ACC_LOAD;
			end
			4'd4: begin
				c.mul = MUL_KD_RATE;
				c.acc = ACC_ADD_SHR;
			end
			4'd5: begin
				c.mul = MUL_KF_DES;
				c.acc = ACC_SUB;
			end
			4'd6: begin
				c.mul = MUL_PI_DT;
				c.acc = ACC_ADD;
			end
			4'd7: c.acc = ACC_RAW;
			4'd8: begin
				c.acc  = ACC_SLEW;
				c.cond = COND_OUT;
				c.last = 1'b1;
			end
			default: c.last = 1'b1;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- sv/pid_feedforward_slew_limited_steer.sv -----
// roll steering controller: pid with feedforward, slew limit and clamp
//
// input stream s_*: one request per sample with desired roll, measured roll
// and roll rate (signed Q3.12 at the default fraction width)
// output stream m_*: one steering command per request, signed, 13 bits
// config channel cfg_*: register index and 16-bit data, always ready;
// index 0..4 = kp, ki, kd, kf, dt; other indexes are dropped
// a microcoded sequencer walks a 9-step program over one shared 32x18
// multiplier and a 40-bit accumulator; six products per request
// s_tready is high only in the idle step; the result is registered in the
// last program step, and a new request is taken only after the sequencer
// has returned to the idle step, so one request is processed at a time
// if the receiver stalls, the finished result waits in the output register
// and the last program step holds until that register frees up
// reset clears the integrator and the stored steer, loads the register
// defaults and returns the sequencer to its idle step
`default_nettype none
module pid_feedforward_slew_limited_steer #(
	parameter int ANGLE_FRAC_BITS = pfss_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,   // desired_roll, actual_roll, roll_rate
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // steer_angle, zero pad
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data
);

	localparam int F = ANGLE_FRAC_BITS;
	localparam longint INTEG_LIM_L = longint'(5) << (F + 12);
	localparam longint STEER_LIM_L =
		(pfss_pkg::PI_Q28 + (longint'(1) << (29 - F))) >> (30 - F);
	localparam logic signed [33:0] INTEG_HI = 34'(INTEG_LIM_L);
	localparam logic signed [33:0] INTEG_LO = -34'(INTEG_LIM_L);
	localparam logic signed [19:0] STEER_HI = 20'(STEER_LIM_L);
	localparam logic signed [19:0] STEER_LO = -20'(STEER_LIM_L);
	localparam int STEP_SHIFT = 43 - F;

	pfss_pkg::ctrl_t ctrl;
	logic            in_fire;
	logic            out_free;

	logic signed [15:0] kp_q, ki_q, kd_q, kf_q;
	logic        [15:0] dt_q;
	logic signed [15:0] des_q, act_q, rate_q;
	logic signed [16:0] err;

	logic signed [31:0] integ_q;
	logic signed [15:0] last_q;
	logic signed [pfss_pkg::PROD_W-1:0] prod_q;
	logic signed [pfss_pkg::SUM_W-1:0]  sum_q;
	logic signed [15:0] raw_q;
	logic        [pfss_pkg::SLEW_W-1:0] lim_q;
	logic                               m_tvalid_q;
	logic        [pfss_pkg::OUT_W-1:0]  out_q;

	logic signed [31:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [33:0] integ_sum;
	logic signed [33:0] integ_sat;
	logic signed [pfss_pkg::PROD_W-1:0] prod_shr4;
	logic signed [pfss_pkg::PROD_W-1:0] prod_shr12;
	logic        [pfss_pkg::PROD_W-1:0] prod_step;
	logic signed [pfss_pkg::SUM_W-1:0]  sum_shr8;
	logic signed [15:0] raw_sat;
	logic signed [19:0] diff;
	logic signed [19:0] lim_s;
	logic signed [19:0] slew;
	logic signed [19:0] slew_sat;

	pfss_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	assign s_tready  = (ctrl.cond == pfss_pkg::COND_IN);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {3'b000, out_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= pfss_pkg::RST_GAIN_PROP;
			ki_q <= pfss_pkg::RST_GAIN_INTEG;
			kd_q <= pfss_pkg::RST_GAIN_DERIV;
			kf_q <= pfss_pkg::RST_GAIN_FEEDFWD;
			dt_q <= pfss_pkg::RST_TIME_STEP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pfss_pkg::REG_GAIN_PROP:    kp_q <= cfg_data;
				pfss_pkg::REG_GAIN_INTEG:   ki_q <= cfg_data;
				pfss_pkg::REG_GAIN_DERIV:   kd_q <= cfg_data;
				pfss_pkg::REG_GAIN_FEEDFWD: kf_q <= cfg_data;
				pfss_pkg::REG_TIME_STEP:    dt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			des_q  <= s_tdata[15:0];
			act_q  <= s_tdata[31:16];
			rate_q <= s_tdata[47:32];
		end
	end

	assign err = 17'(des_q) - 17'(act_q);

	// shared multiplier operand select
	always_comb begin
		case (ctrl.mul)
			pfss_pkg::MUL_ERR_DT: begin
				mul_a = 32'(err);
				mul_b = {2'b00, dt_q};
			end
			pfss_pkg::MUL_KP_ERR: begin
				mul_a = 32'(err);
				mul_b = 18'(kp_q);
			end
			pfss_pkg::MUL_KI_INT: begin
				mul_a = integ_q;
				mul_b = 18'(ki_q);
			end
			pfss_pkg::MUL_KD_RATE: begin
				mul_a = 32'(rate_q);
				mul_b = 18'(kd_q);
			end
			pfss_pkg::MUL_KF_DES: begin
				mul_a = 32'(des_q);
				mul_b = 18'(kf_q);
			end
			pfss_pkg::MUL_PI_DT: begin
				mul_a = 32'(pfss_pkg::PI_Q28);
				mul_b = {2'b00, dt_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 50'(mul_a) * 50'(mul_b);
	end

	// accumulator side arithmetic
	always_comb begin
		prod_shr4  = prod_q >>> 4;
		prod_shr12 = prod_q >>> 12;
		prod_step  = prod_q >> STEP_SHIFT;
		integ_sum  = 34'(integ_q) + prod_shr4[33:0];
		if (integ_sum > INTEG_HI) begin
			integ_sat = INTEG_HI;
		end else if (integ_sum < INTEG_LO) begin
			integ_sat = INTEG_LO;
		end else begin
			integ_sat = integ_sum;
		end
		sum_shr8 = sum_q >>> 8;
		if (sum_shr8 > 40'sd32767) begin
			raw_sat = 16'sh7fff;
		end else if (sum_shr8 < -40'sd32768) begin
			raw_sat = 16'sh8000;
		end else begin
			raw_sat = sum_shr8[15:0];
		end
		diff  = 20'(raw_q) - 20'(last_q);
		lim_s = {2'b00, lim_q};
		if (diff > lim_s) begin
			slew = 20'(last_q) + lim_s;
		end else if (diff < -lim_s) begin
			slew = 20'(last_q) - lim_s;
		end else begin
			slew = 20'(raw_q);
		end
		if (slew > STEER_HI) begin
			slew_sat = STEER_HI;
		end else if (slew < STEER_LO) begin
			slew_sat = STEER_LO;
		end else begin
			slew_sat = slew;
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.acc)
			pfss_pkg::ACC_LOAD:    sum_q <= prod_q[pfss_pkg::SUM_W-1:0];
			pfss_pkg::ACC_ADD_SHR: sum_q <= sum_q + prod_shr12[pfss_pkg::SUM_W-1:0];
			pfss_pkg::ACC_SUB:     sum_q <= sum_q - prod_q[pfss_pkg::SUM_W-1:0];
			pfss_pkg::ACC_ADD:     sum_q <= sum_q + prod_q[pfss_pkg::SUM_W-1:0];
			pfss_pkg::ACC_RAW: begin
				raw_q <= raw_sat;
				lim_q <= prod_step[pfss_pkg::SLEW_W-1:0];
			end
			default: ;
		endcase
	end

	// controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			last_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctrl.acc == pfss_pkg::ACC_INTEG) begin
				integ_q <= integ_sat[31:0];
			end
			if (ctrl.acc == pfss_pkg::ACC_SLEW && out_free) begin
				last_q     <= slew_sat[15:0];
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc == pfss_pkg::ACC_SLEW && out_free) begin
			out_q <= slew_sat[pfss_pkg::OUT_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- sv/pfss_seq.sv -----
// step counter and control store of the microcoded sequencer
`default_nettype none
module pfss_seq (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_fire,
	input  wire             out_free,
	output pfss_pkg::ctrl_t ctrl
);

	logic [pfss_pkg::STEP_W-1:0] step_q;
	logic [pfss_pkg::STEP_W-1:0] step_nxt;
	logic                        adv;

	assign ctrl = pfss_pkg::ucode(step_q);

	always_comb begin
		case (ctrl.cond)
			pfss_pkg::COND_IN:  adv = in_fire;
			pfss_pkg::COND_OUT: adv = out_free;
			default:            adv = 1'b1;
		endcase
		if (!adv) begin
			step_nxt = step_q;
		end else if (ctrl.last) begin
			step_nxt = '0;
		end else begin
			step_nxt = step_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule
`default_nettype wire

// ----- tb/pid_feedforward_slew_limited_steer_tb.sv -----
// self-checking testbench of the roll steering controller with a bit-exact predictor
`timescale 1ns / 100ps
module pid_feedforward_slew_limited_steer_tb;

	localparam int     FRAC       = pfss_pkg::ANGLE_FRAC_BITS_DEF;
	localparam longint INTEG_LIM  = longint'(5) << (FRAC + 12);
	localparam longint STEER_LIM  =
		(pfss_pkg::PI_Q28 + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
	localparam int     CYCLE_LIM  = 500000;
	localparam int     SETTLE     = 16;
	localparam int     PHASES     = 8;
	localparam int     PHASE_LEN  = 200;
	localparam int     TAIL_LEN   = 150;

	typedef struct packed {
		logic signed [15:0] rate;
		logic signed [15:0] actual;
		logic signed [15:0] desired;
	} roll_sample_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	// predictor state and register copy
	logic signed [15:0] kp_reg, ki_reg, kd_reg, kf_reg;
	logic        [15:0] dt_reg;
	longint             integ_acc;
	longint             steer_prev;

	roll_sample_t       pending[$];
	logic        [12:0] steer_exp[$];
	roll_sample_t       src_cur;
	int                 src_gap = 0;
	int                 sink_gap = 0;
	int                 src_idle_pct = 0;
	int                 sink_idle_pct = 0;
	bit                 src_hold = 1'b0;
	int                 fail_cnt = 0;
	int                 cycle_cnt = 0;

	pid_feedforward_slew_limited_steer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint sat(input longint x, input longint lo, input longint hi);
		if (x > hi)
			return hi;
		if (x < lo)
			return lo;
		return x;
	endfunction

	function automatic logic [12:0] steer_predict(input roll_sample_t s);
		longint des, act, rat, dt, err, acc, prod_sum, raw, slew, diff, nxt;
		des = s.desired;
		act = s.actual;
		rat = s.rate;
		dt  = longint'(dt_reg);
		err = des - act;
		acc = sat(integ_acc + ((err * dt) >>> 4), -INTEG_LIM, INTEG_LIM);
		integ_acc = acc;
		prod_sum = longint'(kp_reg) * err + ((longint'(ki_reg) * acc) >>> 12)
			- longint'(kd_reg) * rat + longint'(kf_reg) * des;
		raw  = sat(prod_sum >>> 8, -32768, 32767);
		slew = (pfss_pkg::PI_Q28 * dt) >>> (43 - FRAC);
		diff = raw - steer_prev;
		if (diff > slew)
			nxt = steer_prev + slew;
		else if (diff < -slew)
			nxt = steer_prev - slew;
		else
			nxt = raw;
		nxt = sat(nxt, -STEER_LIM, STEER_LIM);
		steer_prev = nxt;
		return nxt[12:0];
	endfunction

	function automatic logic [15:0] rand_gain();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($urandom);
			default: return 16'(int'($urandom_range(0, 1536)) - 768);
		endcase
	endfunction

	function automatic logic [15:0] rand_dt();
		case ($urandom_range(0, 5))
			0: return 16'hffff;
			1: return 16'h0001;
			2: return 16'($urandom);
			default: return 16'($urandom_range(16, 1000));
		endcase
	endfunction

	function automatic roll_sample_t rand_sample();
		roll_sample_t s;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				s.desired = 16'($urandom);
				s.actual  = 16'($urandom);
				s.rate    = 16'($urandom);
			end
			9: begin
				s.desired = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				s.actual  = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				s.rate    = 16'($urandom);
			end
			default: begin
				// small lean near the target, as in normal riding
				s.desired = 16'(int'($urandom_range(0, 4095)) - 2048);
				s.actual  = 16'(int'(s.desired) + int'($urandom_range(0, 1023)) - 512);
				s.rate    = 16'(int'($urandom_range(0, 8191)) - 4096);
			end
		endcase
		return s;
	endfunction

	task automatic push_sample(input int d, input int a, input int r);
		roll_sample_t s;
		s.desired = 16'(d);
		s.actual  = 16'(a);
		s.rate    = 16'(r);
		pending.push_back(s);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			pfss_pkg::REG_GAIN_PROP:    kp_reg = val;
			pfss_pkg::REG_GAIN_INTEG:   ki_reg = val;
			pfss_pkg::REG_GAIN_DERIV:   kd_reg = val;
			pfss_pkg::REG_GAIN_FEEDFWD: kf_reg = val;
			pfss_pkg::REG_TIME_STEP:    dt_reg = val;
			default: ;
		endcase
	endtask

	task automatic cfg_gains(input logic [15:0] kp, input logic [15:0] ki,
			input logic [15:0] kd, input logic [15:0] kf, input logic [15:0] dt);
		cfg_write(pfss_pkg::REG_GAIN_PROP, kp);
		cfg_write(pfss_pkg::REG_GAIN_INTEG, ki);
		cfg_write(pfss_pkg::REG_GAIN_DERIV, kd);
		cfg_write(pfss_pkg::REG_GAIN_FEEDFWD, kf);
		cfg_write(pfss_pkg::REG_TIME_STEP, dt);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending.size() != 0 || s_tvalid || steer_exp.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				steer_exp.push_back(steer_predict(src_cur));
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					src_gap = src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (src_hold || pending.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if ($urandom_range(0, 99) < src_idle_pct) begin
					src_gap = $urandom_range(0, 12);
					s_tvalid <= 1'b0;
				end else begin
					src_cur = pending.pop_front();
					s_tdata  <= {src_cur.rate, src_cur.actual, src_cur.desired};
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		logic [12:0] want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (steer_exp.size() == 0) begin
					$error("steer_angle: unexpected result %0d", $signed(m_tdata[12:0]));
					fail_cnt++;
				end else begin
					want = steer_exp.pop_front();
					if (m_tdata[12:0] !== want) begin
						$error("steer_angle mismatch: expected %0d, actual %0d",
							$signed(want), $signed(m_tdata[12:0]));
						fail_cnt++;
					end
				end
			end
			if (sink_gap != 0) begin
				sink_gap = sink_gap - 1;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 99) < sink_idle_pct) begin
				sink_gap = $urandom_range(0, 12);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIM) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		kp_reg     = pfss_pkg::RST_GAIN_PROP;
		ki_reg     = pfss_pkg::RST_GAIN_INTEG;
		kd_reg     = pfss_pkg::RST_GAIN_DERIV;
		kf_reg     = pfss_pkg::RST_GAIN_FEEDFWD;
		dt_reg     = pfss_pkg::RST_TIME_STEP;
		integ_acc  = 0;
		steer_prev = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, field extremes
		push_sample(0, 0, 0);
		push_sample(32767, -32768, 0);
		push_sample(-32768, 32767, 0);
		push_sample(0, 0, 32767);
		push_sample(0, 0, -32768);
		push_sample(32767, 32767, 32767);
		push_sample(32767, 32767, 32767);
		push_sample(-32768, -32768, -32768);
		wait_idle();

		// gain extremes, full time step, writes to unused indexes
		cfg_gains(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'hffff);
		cfg_write(3'd5, 16'hffff);
		cfg_write(3'd6, 16'h0000);
		cfg_write(3'd7, 16'h1234);
		cfg_valid <= 1'b0;
		push_sample(32767, -32768, 32767);
		push_sample(-32768, 32767, -32768);
		push_sample(32767, -32768, -32768);
		push_sample(100, -100, 5);
		push_sample(-32768, 32767, 32767);
		wait_idle();

		cfg_gains(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0001);
		push_sample(32767, -32768, 32767);
		push_sample(-32768, 32767, -32768);
		push_sample(-1, 0, 1);
		wait_idle();

		// zero time step: integral and steer hold
		cfg_gains(16'h0100, 16'h0200, 16'h0040, 16'h0880, 16'h0000);
		push_sample(32767, -32768, 0);
		push_sample(-32768, 32767, 0);
		push_sample(1000, 0, -1000);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			cfg_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_dt());
			src_idle_pct  = (p % 3 == 0) ? 0 : $urandom_range(5, 45);
			sink_idle_pct = (p % 4 == 1) ? 0 : $urandom_range(5, 45);
			for (int i = 0; i < PHASE_LEN / 2; i++)
				pending.push_back(rand_sample());
			if (p == 2) begin
				while (pending.size() > PHASE_LEN / 4)
					@(posedge clk);
				src_hold = 1'b1;
				while (s_tvalid || steer_exp.size() != 0)
					@(posedge clk);
				src_hold = 1'b0;
			end
			for (int i = 0; i < PHASE_LEN / 2; i++)
				pending.push_back(rand_sample());
			wait_idle();
		end

		cfg_gains(16'h0180, 16'h0040, 16'h0020, 16'h0880, 16'd328);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		for (int i = 0; i < TAIL_LEN; i++)
			pending.push_back(rand_sample());
		wait_idle();

		if (fail_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
